[hw/rtl/dtq_pkg.sv]
// Shared types and constants for the deadline timer queue.
package dtq_pkg;

  localparam int unsigned DEADLINE_W = 64;
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned ORDER_W    = 32;
  localparam int unsigned LEFT_W     = 5;

  // most entries one release request may pop
  localparam logic [4:0] MAX_OUT = 5'd16;

  typedef enum logic [1:0] {
    KIND_SCHEDULE = 2'd0,
    KIND_RELEASE  = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_RELEASED = 3'd1,
    ST_NONE_DUE = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RD_HOLE = 2'd0,
    RD_SCAN = 2'd1,
    RD_HEAD = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [HANDLE_W-1:0]   owner;
    logic [HANDLE_W-1:0]   job;
    logic [ORDER_W-1:0]    order;
  } entry_t;

  typedef struct packed {
    logic    load_in;
    logic    ins_start;
    logic    ins_shift;
    logic    ins_place;
    logic    scan_start;
    logic    scan_hit;
    logic    pop_emit;
    logic    resp_load;
    logic    clear;
    logic    rd_en;
    rd_src_t rd_src;
    status_t resp_status;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  full;
    logic  k_zero;
    logic  shift_needed;
    logic  rd_due;
    logic  scan_more;
    logic  due_zero;
    logic  last_pop;
    logic  out_free;
  } sts_t;

endpackage

[hw/rtl/dtq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dtq_ram #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/dtq_datapath.sv]
// Datapath: request capture, ring pointers, entry memory and result register.
module dtq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dtq_pkg::cmd_t             cmd,
  output dtq_pkg::sts_t             sts,
  input  logic [1:0]                in_kind,
  input  logic [31:0]               in_delay_ticks,
  input  logic [63:0]               in_current_time,
  input  logic [31:0]               in_owner_handle,
  input  logic [31:0]               in_job_handle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                out_status,
  output logic [31:0]               out_owner,
  output logic [31:0]               out_job,
  output logic [63:0]               out_deadline,
  output logic [4:0]                out_entries_left,
  output logic                      out_last
);
  import dtq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = CNT_W + LEFT_W;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
    idx_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] p);
    idx_dec = (p == '0) ? IDX_W'(CAPACITY - 1) : p - 1'b1;
  endfunction

  // captured request
  kind_t                 kind_r;
  logic [DEADLINE_W-1:0] new_deadline_r;
  logic [DEADLINE_W-1:0] now_r;
  logic [HANDLE_W-1:0]   new_owner_r;
  logic [HANDLE_W-1:0]   new_job_r;

  // ring state
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ORDER_W-1:0] seq_r, seq_nxt;

  // walk state
  logic [IDX_W-1:0] hole_r, hole_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [4:0]       scan_n_r, scan_n_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [HANDLE_W-1:0]   out_owner_r;
  logic [HANDLE_W-1:0]   out_job_r;
  logic [DEADLINE_W-1:0] out_deadline_r;
  logic [LEFT_W-1:0]     out_left_r;
  logic                  out_last_r;

  logic [DEADLINE_W:0]   sum;
  logic [DEADLINE_W-1:0] sat_deadline;
  logic [CNT_W:0]        tail_sum;
  logic [IDX_W-1:0]      tail;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;
  entry_t                wr_entry;
  entry_t                rd_entry;
  logic [$bits(entry_t)-1:0] rd_raw;
  logic [CNT_W-1:0]      left_cnt;
  logic [CMP_W-1:0]      left_ext;
  logic [CMP_W-1:0]      scan_ext;
  logic [CMP_W-1:0]      count_ext;

  // saturating deadline
  assign sum          = {1'b0, in_current_time} + {{(DEADLINE_W - DELAY_W + 1){1'b0}}, in_delay_ticks};
  assign sat_deadline = sum[DEADLINE_W] ? '1 : sum[DEADLINE_W-1:0];

  // slot just past the entry with the latest deadline
  assign tail_sum = {1'b0, (CNT_W)'(head_r)} + {1'b0, count_r};
  assign tail     = (tail_sum >= (CNT_W + 1)'(CAPACITY)) ?
                    IDX_W'(tail_sum - (CNT_W + 1)'(CAPACITY)) : IDX_W'(tail_sum);

  always_comb begin
    case (cmd.rd_src)
      RD_HOLE: rd_addr = idx_dec(hole_r);
      RD_SCAN: rd_addr = scan_idx_r;
      RD_HEAD: rd_addr = head_r;
      default: rd_addr = head_r;
    endcase
  end

  assign rd_entry = entry_t'(rd_raw);
  assign wr_en    = cmd.ins_shift | cmd.ins_place;
  assign wr_addr  = hole_r;

  always_comb begin
    if (cmd.ins_shift) begin
      wr_entry = rd_entry;
    end else begin
      wr_entry.deadline = new_deadline_r;
      wr_entry.owner    = new_owner_r;
      wr_entry.job      = new_job_r;
      wr_entry.order    = seq_r;
    end
  end

  dtq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r         <= kind_t'(in_kind);
      new_deadline_r <= sat_deadline;
      now_r          <= in_current_time;
      new_owner_r    <= in_owner_handle;
      new_job_r      <= in_job_handle;
    end
  end

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    seq_nxt      = seq_r;
    hole_nxt     = hole_r;
    k_nxt        = k_r;
    scan_idx_nxt = scan_idx_r;
    scan_n_nxt   = scan_n_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end
    if (cmd.ins_start) begin
      hole_nxt = tail;
      k_nxt    = count_r;
    end
    if (cmd.ins_shift) begin
      hole_nxt = idx_dec(hole_r);
      k_nxt    = k_r - 1'b1;
    end
    if (cmd.ins_place) begin
      count_nxt = count_r + 1'b1;
      seq_nxt   = seq_r + 1'b1;
    end
    if (cmd.scan_start) begin
      scan_idx_nxt = head_r;
      scan_n_nxt   = '0;
    end
    if (cmd.scan_hit) begin
      scan_idx_nxt = idx_inc(scan_idx_r);
      scan_n_nxt   = scan_n_r + 1'b1;
    end
    if (cmd.pop_emit) begin
      head_nxt   = idx_inc(head_r);
      count_nxt  = count_r - 1'b1;
      scan_n_nxt = scan_n_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hole_r     <= hole_nxt;
    k_r        <= k_nxt;
    scan_idx_r <= scan_idx_nxt;
    scan_n_r   <= scan_n_nxt;
  end

  // result register
  assign left_cnt = cmd.pop_emit ? count_r - 1'b1 : count_r;
  assign left_ext = {{LEFT_W{1'b0}}, left_cnt};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pop_emit || cmd.resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_emit) begin
      out_status_r   <= ST_RELEASED;
      out_owner_r    <= rd_entry.owner;
      out_job_r      <= rd_entry.job;
      out_deadline_r <= rd_entry.deadline;
      out_left_r     <= left_ext[LEFT_W-1:0];
      out_last_r     <= (scan_n_r == 5'd1);
    end else if (cmd.resp_load) begin
      out_status_r   <= cmd.resp_status;
      out_owner_r    <= '0;
      out_job_r      <= '0;
      out_deadline_r <= '0;
      out_left_r     <= left_ext[LEFT_W-1:0];
      out_last_r     <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_owner        = out_owner_r;
  assign out_job          = out_job_r;
  assign out_deadline     = out_deadline_r;
  assign out_entries_left = out_left_r;
  assign out_last         = out_last_r;

  // status to controller
  assign scan_ext  = {{CNT_W{1'b0}}, scan_n_r};
  assign count_ext = {{LEFT_W{1'b0}}, count_r};

  assign sts.kind         = kind_r;
  assign sts.full         = (count_r == CNT_W'(CAPACITY));
  assign sts.k_zero       = (k_r == '0);
  assign sts.shift_needed = (rd_entry.deadline > new_deadline_r);
  assign sts.rd_due       = (rd_entry.deadline <= now_r);
  assign sts.scan_more    = (scan_n_r != MAX_OUT) && (scan_ext < count_ext);
  assign sts.due_zero     = (scan_n_r == '0);
  assign sts.last_pop     = (scan_n_r == 5'd1);
  assign sts.out_free     = !out_valid_r || out_ready;

endmodule

[hw/rtl/dtq_ctrl.sv]
// Controller: sequences insert walks, release scans and pops, and responses.
module dtq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtq_pkg::sts_t sts,
  output dtq_pkg::cmd_t cmd
);
  import dtq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DECODE   = 9'b000000010,
    S_INS_RD   = 9'b000000100,
    S_INS_CMP  = 9'b000001000,
    S_SCAN_RD  = 9'b000010000,
    S_SCAN_CMP = 9'b000100000,
    S_POP_RD   = 9'b001000000,
    S_POP_OUT  = 9'b010000000,
    S_RESP     = 9'b100000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t resp_r, resp_nxt;

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd       = '0;
    cmd.rd_src      = RD_HEAD;
    cmd.resp_status = resp_r;
    in_ready  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.kind)
          KIND_SCHEDULE: begin
            if (sts.full) begin
              resp_nxt  = ST_FULL;
              state_nxt = S_RESP;
            end else begin
              cmd.ins_start = 1'b1;
              state_nxt     = S_INS_RD;
            end
          end
          KIND_RELEASE: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN_RD;
          end
          KIND_CLEAR: begin
            cmd.clear = 1'b1;
            resp_nxt  = ST_CLEARED;
            state_nxt = S_RESP;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_INS_RD: begin
        if (sts.k_zero) begin
          cmd.ins_place = 1'b1;
          resp_nxt      = ST_ACCEPTED;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_HOLE;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts.shift_needed) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          resp_nxt      = ST_ACCEPTED;
          state_nxt     = S_RESP;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_SCAN;
          state_nxt  = S_SCAN_CMP;
        end else if (sts.due_zero) begin
          resp_nxt  = ST_NONE_DUE;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_SCAN_CMP: begin
        if (sts.rd_due) begin
          cmd.scan_hit = 1'b1;
          state_nxt    = S_SCAN_RD;
        end else if (sts.due_zero) begin
          resp_nxt  = ST_NONE_DUE;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_POP_RD;
        end
      end
      S_POP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = RD_HEAD;
        state_nxt  = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (sts.out_free) begin
          cmd.pop_emit = 1'b1;
          state_nxt    = sts.last_pop ? S_IDLE : S_POP_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= ST_ACCEPTED;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

[hw/rtl/deadline_timer_queue.sv]
// Deadline timer queue: a bounded store of timed entries released earliest first.
//
// Usage and timing. The block holds up to CAPACITY entries in one RAM used as
// a ring, kept sorted by deadline (ties in arrival order), earliest deadline at
// the head. A schedule request (kind 0) stores owner and job with deadline =
// current_time + delay_ticks, saturating at the all-ones value, and answers
// with one accepted result, or one full-refused result when the store is full.
// A release request (kind 1) pops every entry whose deadline is not after
// current_time, at most 16 per request, as released results earliest first,
// the final one flagged by last; with nothing due it gives one none-due result.
// A clear request (kind 2) empties the store and answers once; kind 3 is
// dropped without a result. entries_left is the stored count after the
// result, modulo 32. One request is worked at a time; in_ready is high only
// between requests. Each entry that is examined is read from the entry RAM,
// which has a single read port, in a read state and then checked in a
// compare state. A schedule walks down from the tail, sliding each stored
// entry with a later deadline up one slot, and writes the new entry into
// the hole where the walk stops; a full store is refused without a walk.
// A release scans from the head until it meets an entry that is not yet
// due, has counted 16 due entries or has examined every stored entry, then
// pops the due entries from the head one by one, each read and then emitted.
// Results sit in an output register, so a stalled consumer only delays the
// request that is trying to emit.
module deadline_timer_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_delay_ticks,
  input  logic [63:0] in_current_time,
  input  logic [31:0] in_owner_handle,
  input  logic [31:0] in_job_handle,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_owner,
  output logic [31:0] out_job,
  output logic [63:0] out_deadline,
  output logic [4:0]  out_entries_left,
  output logic        out_last
);
  import dtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decode, insertion walk, due scan, pop loop, single response
  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pointers, counters, entry RAM and result register
  dtq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_kind          (in_kind),
    .in_delay_ticks   (in_delay_ticks),
    .in_current_time  (in_current_time),
    .in_owner_handle  (in_owner_handle),
    .in_job_handle    (in_job_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_owner        (out_owner),
    .out_job          (out_job),
    .out_deadline     (out_deadline),
    .out_entries_left (out_entries_left),
    .out_last         (out_last)
  );

endmodule

[tb/sv/tb_deadline_timer_queue.sv]
// Self-checking testbench for the deadline timer queue.
`timescale 1ns / 1ps

module tb_deadline_timer_queue;
  import dtq_pkg::*;

  localparam int STORE_DEPTH = 16;
  // The longest quiet stretch is the long receiver hold-off or one 16-entry
  // release. The limit sits well above both.
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;

  // one request as offered on the input channel
  typedef struct {
    kind_t       kind;
    logic [31:0] delay;
    logic [63:0] now;
    logic [31:0] owner;
    logic [31:0] job;
    bit          drain;   // sender waits for all results before offering this one
  } timer_req_t;

  // one result as seen on the output channel
  typedef struct {
    status_t     status;
    logic [31:0] owner;
    logic [31:0] job;
    logic [63:0] deadline;
    logic [4:0]  left;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = 2'd0;
  logic [31:0] in_delay_ticks = '0;
  logic [63:0] in_current_time = '0;
  logic [31:0] in_owner_handle = '0;
  logic [31:0] in_job_handle = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_owner;
  logic [31:0] out_job;
  logic [63:0] out_deadline;
  logic [4:0]  out_entries_left;
  logic        out_last;

  deadline_timer_queue #(.CAPACITY(STORE_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_delay_ticks   (in_delay_ticks),
    .in_current_time  (in_current_time),
    .in_owner_handle  (in_owner_handle),
    .in_job_handle    (in_job_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_owner        (out_owner),
    .out_job          (out_job),
    .out_deadline     (out_deadline),
    .out_entries_left (out_entries_left),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  timer_req_t    pending_reqs[$];
  timer_result_t expected_results[$];

  // predictor copy of the sorted timer store
  logic [63:0] timer_deadline [STORE_DEPTH];
  logic [31:0] timer_owner    [STORE_DEPTH];
  logic [31:0] timer_job      [STORE_DEPTH];
  int          timer_count = 0;

  int errors = 0;
  int reqs_accepted = 0;
  int results_checked = 0;
  int n_sched = 0, n_full = 0, n_release = 0, n_popped = 0, n_clear = 0, n_ignored = 0;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // append to the tail of the request and expectation queues
  function automatic void add_req(timer_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_expected(timer_result_t res);
    expected_results.insert(expected_results.size(), res);
  endfunction

  function automatic timer_result_t plain_result(status_t st, int left);
    timer_result_t res;
    res.status   = st;
    res.owner    = '0;
    res.job      = '0;
    res.deadline = '0;
    res.left     = left[4:0];
    res.last     = 1'b1;
    return res;
  endfunction

  function automatic timer_req_t mk_req(kind_t k, logic [31:0] d, logic [63:0] t,
                                        logic [31:0] o, logic [31:0] j);
    timer_req_t r;
    r.kind  = k;
    r.delay = d;
    r.now   = t;
    r.owner = o;
    r.job   = j;
    r.drain = 1'b0;
    return r;
  endfunction

  // Apply one accepted request to the store copy and queue its results.
  task automatic predict_request(input timer_req_t r);
    timer_result_t res;
    logic [64:0]   sum;
    logic [63:0]   dl;
    int            pos;
    int            due;
    case (r.kind)
      KIND_SCHEDULE: begin
        n_sched++;
        if (timer_count >= STORE_DEPTH) begin
          // store full: refused, nothing changes
          n_full++;
          add_expected(plain_result(ST_FULL, timer_count));
        end else begin
          sum = {1'b0, r.now} + {33'd0, r.delay};
          dl  = sum[64] ? '1 : sum[63:0];   // deadline saturates at all ones
          // goes in after every entry with an equal or earlier deadline
          pos = 0;
          while (pos < timer_count && timer_deadline[pos] <= dl) pos++;
          for (int i = timer_count; i > pos; i--) begin
            timer_deadline[i] = timer_deadline[i-1];
            timer_owner[i]    = timer_owner[i-1];
            timer_job[i]      = timer_job[i-1];
          end
          timer_deadline[pos] = dl;
          timer_owner[pos]    = r.owner;
          timer_job[pos]      = r.job;
          timer_count++;
          add_expected(plain_result(ST_ACCEPTED, timer_count));
        end
      end
      KIND_RELEASE: begin
        n_release++;
        due = 0;
        while (due < timer_count && due < int'(MAX_OUT) && timer_deadline[due] <= r.now) due++;
        if (due == 0) begin
          add_expected(plain_result(ST_NONE_DUE, timer_count));
        end else begin
          for (int i = 0; i < due; i++) begin
            res          = plain_result(ST_RELEASED, timer_count - (i + 1));
            res.owner    = timer_owner[i];
            res.job      = timer_job[i];
            res.deadline = timer_deadline[i];
            res.last     = (i + 1 == due);
            add_expected(res);
          end
          for (int i = due; i < timer_count; i++) begin
            timer_deadline[i-due] = timer_deadline[i];
            timer_owner[i-due]    = timer_owner[i];
            timer_job[i-due]      = timer_job[i];
          end
          timer_count -= due;
          n_popped += due;
        end
      end
      KIND_CLEAR: begin
        n_clear++;
        timer_count = 0;
        add_expected(plain_result(ST_CLEARED, 0));
      end
      default: n_ignored++;   // kind 3: dropped, no result
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers requests from pending_reqs in bursts with random gaps.
  // A request flagged drain is held back until every expected result is in.
  // ---------------------------------------------------------------------------
  timer_req_t cur_req;
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(cur_req);
        reqs_accepted++;
      end
      if (in_valid && !in_ready) begin
        // request still waiting: hold valid and payload
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0 ||
                   (pending_reqs[0].drain && expected_results.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        in_valid        <= 1'b1;
        in_kind         <= cur_req.kind;
        in_delay_ticks  <= cur_req.delay;
        in_current_time <= cur_req.now;
        in_owner_handle <= cur_req.owner;
        in_job_handle   <= cur_req.job;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          // a stretch with no sender idling at all
          if (reqs_accepted >= 60 && reqs_accepted < 110) gap_left <= 0;
          else gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a rotating pattern; once, it holds off for a long
  // stretch so the output register and then the input side back up.
  // ---------------------------------------------------------------------------
  int       hold_cycles = 0;
  bit       hold_done = 1'b0;
  bit [7:0] ready_phase = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else if (!hold_done && reqs_accepted >= 120) begin
      hold_cycles <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_ready   <= 1'b0;
    end else begin
      ready_phase <= ready_phase + 1'b1;
      case (ready_phase[7:6])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ready_phase[0];
        2'd2: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    timer_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d", out_status));
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (out_status !== exp_r.status)
          report_mismatch($sformatf("status got %0d exp %0d", out_status, exp_r.status));
        if (out_owner !== exp_r.owner)
          report_mismatch($sformatf("owner got %h exp %h", out_owner, exp_r.owner));
        if (out_job !== exp_r.job)
          report_mismatch($sformatf("job got %h exp %h", out_job, exp_r.job));
        if (out_deadline !== exp_r.deadline)
          report_mismatch($sformatf("deadline got %h exp %h", out_deadline, exp_r.deadline));
        if (out_entries_left !== exp_r.left)
          report_mismatch($sformatf("entries_left got %0d exp %0d",
                                    out_entries_left, exp_r.left));
        if (out_last !== exp_r.last)
          report_mismatch($sformatf("last got %b exp %b", out_last, exp_r.last));
      end
    end
  end

  // watchdog: no handshake on either channel for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    timer_req_t  r;
    logic [63:0] tnow;
    logic [63:0] base;
    int          rand_reqs;
    int          pick;
    int          ep;
    int          n_fill;
    int          total_reqs;

    // directed part
    add_req(mk_req(KIND_CLEAR, '0, '0, '0, '0));          // clear when empty
    add_req(mk_req(KIND_SCHEDULE, '0, '0, '0, '0));       // all-zero fields
    add_req(mk_req(KIND_SCHEDULE, '1, '1, '1, '1));       // deadline saturates
    add_req(mk_req(KIND_NONE, $urandom(), {$urandom(), $urandom()},
                   $urandom(), $urandom()));              // unknown kind
    add_req(mk_req(KIND_RELEASE, '1, '0, '1, '1));        // pops deadline 0 only
    // fill to capacity with heavy deadline ties
    for (int i = 0; i < STORE_DEPTH - 1; i++)
      add_req(mk_req(KIND_SCHEDULE, i % 3, 64'd100, 32'hA000_0000 + i,
                     32'h5000_0000 + i));
    add_req(mk_req(KIND_SCHEDULE, 32'd1, 64'd10, 32'hDEAD, 32'hBEEF)); // full
    add_req(mk_req(KIND_RELEASE, '0, '1, '0, '0));        // sixteen at once
    add_req(mk_req(KIND_RELEASE, '0, 64'd5, '0, '0));     // none due
    add_req(mk_req(KIND_SCHEDULE, 32'd7, 64'd5, 32'h1, 32'h2));
    add_req(mk_req(KIND_CLEAR, $urandom(), {$urandom(), $urandom()},
                   $urandom(), $urandom()));              // clear with entries

    // random part, built from episodes
    rand_reqs = 0;
    tnow = 64'd1000;
    while (rand_reqs < 240) begin
      ep = $urandom_range(0, 9);
      if (ep <= 5) begin
        // mixed traffic on a slowly advancing clock
        repeat ($urandom_range(6, 14)) begin
          pick = $urandom_range(0, 99);
          tnow = tnow + $urandom_range(0, 8);
          if (pick < 55)
            r = mk_req(KIND_SCHEDULE,
                       ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40),
                       tnow, $urandom(), $urandom());
          else if (pick < 90)
            r = mk_req(KIND_RELEASE, $urandom(), tnow + $urandom_range(0, 30),
                       $urandom(), $urandom());
          else if (pick < 95)
            r = mk_req(KIND_CLEAR, $urandom(), {$urandom(), $urandom()},
                       $urandom(), $urandom());
          else
            r = mk_req(KIND_NONE, $urandom(), {$urandom(), $urandom()},
                       $urandom(), $urandom());
          r.drain = ($urandom_range(0, 39) == 0);
          add_req(r);
          if (r.kind != KIND_NONE) rand_reqs++;
        end
      end else if (ep == 6) begin
        // fill burst with ties, possibly past capacity, then partial and full release
        base = tnow;
        n_fill = $urandom_range(10, 18);
        for (int i = 0; i < n_fill; i++)
          add_req(mk_req(KIND_SCHEDULE, $urandom_range(0, 3), base,
                         $urandom(), $urandom()));
        add_req(mk_req(KIND_RELEASE, $urandom(), base + $urandom_range(0, 3),
                       $urandom(), $urandom()));
        add_req(mk_req(KIND_RELEASE, $urandom(), base + 10,
                       $urandom(), $urandom()));
        rand_reqs += n_fill + 2;
        tnow = base + 11;
      end else if (ep == 7) begin
        // release far ahead: flushes entries with huge deadlines
        add_req(mk_req(KIND_RELEASE, $urandom(),
                       ($urandom_range(0, 1) == 0) ? '1 : {$urandom(), $urandom()},
                       $urandom(), $urandom()));
        rand_reqs++;
      end else if (ep == 8) begin
        // noise: any kind, any field values
        repeat (4) begin
          r = mk_req(kind_t'($urandom_range(0, 3)), $urandom(), {$urandom(), $urandom()},
                     $urandom(), $urandom());
          add_req(r);
          if (r.kind != KIND_NONE) rand_reqs++;
        end
      end else begin
        // jump the clock, sometimes close to the top so deadlines saturate
        if ($urandom_range(0, 1) == 0) tnow = {$urandom(), $urandom()};
        else tnow = 64'hFFFF_FFFF_FFFF_FF00 - $urandom_range(0, 255);
        add_req(mk_req(KIND_SCHEDULE, $urandom(), tnow, $urandom(), $urandom()));
        rand_reqs++;
      end
    end
    // sender pause partway through the random part
    pending_reqs[pending_reqs.size() > 200 ? pending_reqs.size() - 200 : 0].drain = 1'b1;
    total_reqs = pending_reqs.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < total_reqs) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_results.size()));

    $display("Covered %0d schedules (%0d refused full), %0d releases popping %0d entries,",
             n_sched, n_full, n_release, n_popped);
    $display("%0d clears, %0d ignored requests; %0d results checked, %0d mismatches",
             n_clear, n_ignored, results_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
